### rtl/cartridge_bank_mapper_irq_unit_defines.svh
// Assertion macros shared by the mapper RTL.
`ifndef CARTRIDGE_BANK_MAPPER_IRQ_UNIT_DEFINES_SVH
`define CARTRIDGE_BANK_MAPPER_IRQ_UNIT_DEFINES_SVH

// Clocked property that is not checked while reset is high.
`define CBM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Clocked property that is checked on every edge, reset included.
`define CBM_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### rtl/cbm_pkg.sv
// Types and constants for the cartridge bank mapper with scanline interrupt.
`timescale 1ns / 1ps

package cbm_pkg;

  // Last scanline on which a tick clocks the interrupt counter.
  localparam logic [8:0] LAST_VISIBLE_LINE = 9'd239;

  // Register decode: {address[15:13], address[0]}, i.e. address & 0xE001.
  localparam logic [3:0] DEC_BANK_SELECT = 4'b1000;  // 0x8000
  localparam logic [3:0] DEC_MIRROR      = 4'b1001;  // 0x8001
  localparam logic [3:0] DEC_BANK_DATA   = 4'b1010;  // 0xA000
  localparam logic [3:0] DEC_UNUSED      = 4'b1011;  // 0xA001
  localparam logic [3:0] DEC_IRQ_COUNT   = 4'b1100;  // 0xC000
  localparam logic [3:0] DEC_IRQ_RELOAD  = 4'b1101;  // 0xC001
  localparam logic [3:0] DEC_IRQ_DISABLE = 4'b1110;  // 0xE000
  localparam logic [3:0] DEC_IRQ_ENABLE  = 4'b1111;  // 0xE001

  // Configuration register indexes.
  localparam logic [1:0] CFG_PRG_BANK_COUNT    = 2'd0;
  localparam logic [1:0] CFG_HAS_CHR_ROM       = 2'd1;
  localparam logic [1:0] CFG_FOUR_SCREEN       = 2'd2;
  localparam logic [1:0] CFG_INITIAL_MIRRORING = 2'd3;

  localparam int unsigned CFG_DATA_W = 9;

  // Reset values of the configuration registers.
  localparam logic [8:0] RST_PRG_BANK_COUNT    = 9'd32;
  localparam logic       RST_HAS_CHR_ROM       = 1'b1;
  localparam logic       RST_FOUR_SCREEN       = 1'b0;
  localparam logic       RST_INITIAL_MIRRORING = 1'b0;

  // Bank select fields.
  localparam int unsigned SEL_PRG_SWAP_BIT = 6;
  localparam int unsigned SEL_CHR_SWAP_BIT = 7;

  localparam logic [7:0] CHR_PAIR_MASK = 8'hFE;

  typedef struct packed {
    logic       mode;          // 0 CPU write, 1 scanline tick
    logic [15:0] address;
    logic [7:0]  write_data;
    logic [8:0]  line_number;
    logic        rendering_on;
  } in_item_t;

  typedef struct packed {
    logic [31:0] prg_bank_map;
    logic [63:0] chr_bank_map;
    logic        mirroring;
    logic        irq_pulse;
  } out_item_t;

endpackage

### rtl/cartridge_bank_mapper_irq_unit.sv
// Top level of the cartridge bank mapper with scanline interrupt counter.
//
//   Channel   Signals                        Direction  Carries
//   --------  -----------------------------  ---------  ------------------------------
//   in        in_valid, in_ready, in_data    sink       CPU register write or tick
//   out       out_valid, out_ready, out_data source     bank maps, mirroring, irq pulse
//   cfg       cfg_we, cfg_index, cfg_data    sink       cartridge configuration
//
// One item per clock. The mapper state is updated at the edge that accepts an
// item, and the result built from the updated state is loaded into the output
// register at that same edge, so a result appears in the cycle after its transfer.
// The input is ready whenever the output register is empty or being drained,
// which keeps a full clock rate through a ready output and holds the item back
// only while a finished result waits. Reset is synchronous and restores the
// power-up bank layout and the configuration defaults.
`timescale 1ns / 1ps
`include "cartridge_bank_mapper_irq_unit_defines.svh"

module cartridge_bank_mapper_irq_unit (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  cbm_pkg::in_item_t              in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output cbm_pkg::out_item_t             out_data,
  input  logic                           cfg_we,
  input  logic [1:0]                     cfg_index,
  input  logic [cbm_pkg::CFG_DATA_W-1:0] cfg_data
);

  // Configuration registers. The power-up mirroring needs no register of its
  // own: a write to it goes straight into the live mirroring.
  logic [8:0] prg_bank_count;
  logic       has_chr_rom;
  logic       four_screen;

  // Mapper state.
  logic [7:0] bank_select;
  logic [7:0] prg_regs [2];
  logic [7:0] chr_regs [6];
  logic [7:0] irq_count;
  logic [7:0] irq_reload;
  logic       irq_armed;
  logic       mirror_mode;

  logic [7:0] bank_select_next;
  logic [7:0] prg_regs_next [2];
  logic [7:0] chr_regs_next [6];
  logic [7:0] irq_count_next;
  logic [7:0] irq_reload_next;
  logic       irq_armed_next;
  logic       mirror_mode_next;

  logic               in_accept;
  logic               tick_active;
  logic               irq_fire;
  logic [3:0]         decode;
  logic [2:0]         reg_sel;
  logic [2:0]         chr_sel;
  logic [7:0]         last_m1;
  logic [7:0]         last_m2;
  logic [7:0]         prg_slot [4];
  logic [7:0]         chr_lo [4];
  logic [7:0]         chr_hi [4];
  logic [7:0]         chr_slot [8];
  cbm_pkg::out_item_t result_next;

  assign in_ready  = !out_valid || out_ready;
  assign in_accept = in_valid && in_ready;

  assign decode  = {in_data.address[15:13], in_data.address[0]};
  assign reg_sel = bank_select[2:0];
  assign chr_sel = reg_sel - 3'd2;

  // A tick clocks the counter only when armed, on a visible line, with rendering on.
  assign tick_active = in_data.mode && irq_armed && in_data.rendering_on &&
                       (in_data.line_number <= cbm_pkg::LAST_VISIBLE_LINE);
  assign irq_fire    = tick_active && (irq_count == 8'd0);

  // Next mapper state for the item at the input.
  always_comb begin
    bank_select_next = bank_select;
    prg_regs_next    = prg_regs;
    chr_regs_next    = chr_regs;
    irq_count_next   = irq_count;
    irq_reload_next  = irq_reload;
    irq_armed_next   = irq_armed;
    mirror_mode_next = mirror_mode;
    if (in_data.mode) begin
      if (irq_fire) begin
        irq_count_next = irq_reload;
      end else if (tick_active) begin
        irq_count_next = irq_count - 8'd1;
      end
    end else begin
      case (decode)
        cbm_pkg::DEC_BANK_SELECT: begin
          bank_select_next = in_data.write_data;
        end
        cbm_pkg::DEC_MIRROR: begin
          // Four-screen boards hard-wire their nametables.
          if (!four_screen) begin
            mirror_mode_next = in_data.write_data[0];
          end
        end
        cbm_pkg::DEC_BANK_DATA: begin
          if (reg_sel < 3'd2) begin
            prg_regs_next[reg_sel[0]] = in_data.write_data;
          end else if (has_chr_rom) begin
            // The two 2 KB pattern pairs always start on an even bank.
            if (reg_sel < 3'd4) begin
              chr_regs_next[chr_sel] = in_data.write_data & cbm_pkg::CHR_PAIR_MASK;
            end else begin
              chr_regs_next[chr_sel] = in_data.write_data;
            end
          end
        end
        cbm_pkg::DEC_IRQ_COUNT: begin
          irq_count_next = in_data.write_data;
        end
        cbm_pkg::DEC_IRQ_RELOAD: begin
          irq_reload_next = in_data.write_data;
        end
        cbm_pkg::DEC_IRQ_DISABLE: begin
          // This write also selects mirroring, four-screen boards included.
          irq_armed_next   = 1'b0;
          mirror_mode_next = (in_data.write_data == 8'd0);
        end
        cbm_pkg::DEC_IRQ_ENABLE: begin
          irq_armed_next = 1'b1;
        end
        cbm_pkg::DEC_UNUSED: begin
        end
        default: begin
          // Addresses below the register window leave the state alone.
        end
      endcase
    end
  end

  // Result built from the updated state. The two fixed program slots wrap
  // modulo 256 for counts outside the usual range.
  assign last_m1 = prg_bank_count[7:0] - 8'd1;
  assign last_m2 = prg_bank_count[7:0] - 8'd2;

  always_comb begin
    if (bank_select_next[cbm_pkg::SEL_PRG_SWAP_BIT]) begin
      prg_slot[0] = last_m2;
      prg_slot[2] = prg_regs_next[0];
    end else begin
      prg_slot[0] = prg_regs_next[0];
      prg_slot[2] = last_m2;
    end
    prg_slot[1] = prg_regs_next[1];
    prg_slot[3] = last_m1;

    // Pair registers are even, so the upper half never carries.
    chr_lo[0] = chr_regs_next[0];
    chr_lo[1] = chr_regs_next[0] + 8'd1;
    chr_lo[2] = chr_regs_next[1];
    chr_lo[3] = chr_regs_next[1] + 8'd1;
    for (int i = 0; i < 4; i++) begin
      chr_hi[i] = chr_regs_next[2 + i];
    end
    for (int i = 0; i < 4; i++) begin
      if (bank_select_next[cbm_pkg::SEL_CHR_SWAP_BIT]) begin
        chr_slot[i]     = chr_hi[i];
        chr_slot[4 + i] = chr_lo[i];
      end else begin
        chr_slot[i]     = chr_lo[i];
        chr_slot[4 + i] = chr_hi[i];
      end
    end

    result_next.prg_bank_map = {prg_slot[3], prg_slot[2], prg_slot[1], prg_slot[0]};
    if (has_chr_rom) begin
      result_next.chr_bank_map = {chr_slot[7], chr_slot[6], chr_slot[5], chr_slot[4],
                                  chr_slot[3], chr_slot[2], chr_slot[1], chr_slot[0]};
    end else begin
      result_next.chr_bank_map = 64'd0;
    end
    result_next.mirroring = mirror_mode_next;
    result_next.irq_pulse = irq_fire;
  end

  // Mapper state and configuration. The user must write configuration only while the
  // block is idle, so its writes never meet an item update; the block does not enforce it.
  always_ff @(posedge clk) begin
    if (rst) begin
      prg_bank_count    <= cbm_pkg::RST_PRG_BANK_COUNT;
      has_chr_rom       <= cbm_pkg::RST_HAS_CHR_ROM;
      four_screen       <= cbm_pkg::RST_FOUR_SCREEN;
      bank_select       <= 8'd0;
      prg_regs[0]       <= 8'd0;
      prg_regs[1]       <= 8'd1;
      chr_regs[0]       <= 8'd0;
      chr_regs[1]       <= 8'd2;
      chr_regs[2]       <= 8'd4;
      chr_regs[3]       <= 8'd5;
      chr_regs[4]       <= 8'd6;
      chr_regs[5]       <= 8'd7;
      irq_count         <= 8'd0;
      irq_reload        <= 8'd0;
      irq_armed         <= 1'b0;
      mirror_mode       <= cbm_pkg::RST_INITIAL_MIRRORING;
    end else begin
      if (in_accept) begin
        bank_select <= bank_select_next;
        prg_regs    <= prg_regs_next;
        chr_regs    <= chr_regs_next;
        irq_count   <= irq_count_next;
        irq_reload  <= irq_reload_next;
        irq_armed   <= irq_armed_next;
        mirror_mode <= mirror_mode_next;
      end
      if (cfg_we) begin
        case (cfg_index)
          cbm_pkg::CFG_PRG_BANK_COUNT: begin
            prg_bank_count <= cfg_data[8:0];
          end
          cbm_pkg::CFG_HAS_CHR_ROM: begin
            has_chr_rom <= cfg_data[0];
          end
          cbm_pkg::CFG_FOUR_SCREEN: begin
            four_screen <= cfg_data[0];
          end
          cbm_pkg::CFG_INITIAL_MIRRORING: begin
            // Loading the power-up mirroring also applies it at once.
            mirror_mode <= cfg_data[0];
          end
          default: begin
          end
        endcase
      end
    end
  end

  // Output register: loads on every input transfer, empties on an output transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_data <= result_next;
    end
  end

  // A CPU write never raises an interrupt, and its result is presented next cycle.
  `CBM_ASSERT(a_write_no_irq, (in_accept && !in_data.mode) |=> (out_valid && !out_data.irq_pulse), "write transfer produced an interrupt pulse")
  // An interrupt pulse comes with a reload of the counter from the latch.
  `CBM_ASSERT(a_irq_reloads, (in_accept && irq_fire) |=> (irq_count == $past(irq_reload) && out_data.irq_pulse), "interrupt without counter reload")
  // The 2 KB pattern pairs stay on even banks at all times.
  `CBM_ASSERT_ALWAYS(a_chr_pairs_even, ($past(rst) || rst || (chr_regs[0][0] == 1'b0 && chr_regs[1][0] == 1'b0)), "pattern pair register holds an odd bank")

endmodule

### bench/testbench.sv
// Self-checking testbench for the cartridge bank mapper with scanline interrupt counter.
`timescale 1ns / 1ps

module testbench;

  // Kinds of input transfer.
  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_TICK  = 1'b1;

  // Targets of the bank data register, chosen by the low three bits of bank select.
  localparam logic [2:0] BANK_PRG1      = 3'd1;
  localparam logic [2:0] BANK_CHR_FIRST = 3'd2;
  localparam logic [2:0] BANK_CHR_PAIR1 = 3'd3;

  // Highest scanline number a tick can carry.
  localparam int unsigned LAST_LINE = 261;

  // Length of the forced receiver hold-off, in cycles.
  localparam int LONG_HOLD = 120;
  // Cycles allowed after the last result before the block counts as idle.
  localparam int DRAIN_CYCLES = 4;
  // Hard limit on the whole run, far above the slowest legal run.
  localparam int TIMEOUT_NS = 5_000_000;

  // The scoreboard keeps its own copy of the cartridge configuration and of the
  // mapper state. Every accepted input transfer is run through that copy to build
  // the result the block must return; results are then matched in order.
  class mapper_scoreboard;
    logic [8:0] prg_count;
    logic       chr_rom;
    logic       four_scr;
    logic [7:0] bank_sel;
    logic [7:0] prg_regs[2];
    logic [7:0] chr_regs[6];
    logic [7:0] irq_cnt;
    logic [7:0] irq_rld;
    logic       irq_on;
    logic       mirror;
    cbm_pkg::out_item_t expected_q[$];
    int         errors;

    function new();
      prg_count   = cbm_pkg::RST_PRG_BANK_COUNT;
      chr_rom     = cbm_pkg::RST_HAS_CHR_ROM;
      four_scr    = cbm_pkg::RST_FOUR_SCREEN;
      bank_sel    = 8'd0;
      prg_regs[0] = 8'd0;
      prg_regs[1] = 8'd1;
      chr_regs[0] = 8'd0;
      chr_regs[1] = 8'd2;
      chr_regs[2] = 8'd4;
      chr_regs[3] = 8'd5;
      chr_regs[4] = 8'd6;
      chr_regs[5] = 8'd7;
      irq_cnt     = 8'd0;
      irq_rld     = 8'd0;
      irq_on      = 1'b0;
      mirror      = cbm_pkg::RST_INITIAL_MIRRORING;
      errors      = 0;
    endfunction

    // Writing the power-up mirroring also sets the live mirroring at once.
    function void write_cfg(logic [1:0] idx, logic [cbm_pkg::CFG_DATA_W-1:0] val);
      case (idx)
        cbm_pkg::CFG_PRG_BANK_COUNT: prg_count = val;
        cbm_pkg::CFG_HAS_CHR_ROM:    chr_rom = val[0];
        cbm_pkg::CFG_FOUR_SCREEN:    four_scr = val[0];
        cbm_pkg::CFG_INITIAL_MIRRORING: begin
          mirror = val[0];
        end
        default: ;
      endcase
    endfunction

    function void apply_write(logic [15:0] addr, logic [7:0] data);
      logic [3:0] dec;
      logic [2:0] sel;
      dec = {addr[15:13], addr[0]};
      case (dec)
        cbm_pkg::DEC_BANK_SELECT: bank_sel = data;
        cbm_pkg::DEC_BANK_DATA: begin
          sel = bank_sel[2:0];
          if (sel <= BANK_PRG1) begin
            prg_regs[sel[0]] = data;
          end else if (chr_rom) begin
            // The 2 KB pattern pairs always start on an even bank.
            if (sel <= BANK_CHR_PAIR1)
              chr_regs[sel - BANK_CHR_FIRST] = data & cbm_pkg::CHR_PAIR_MASK;
            else chr_regs[sel - BANK_CHR_FIRST] = data;
          end
        end
        cbm_pkg::DEC_MIRROR: if (!four_scr) mirror = data[0];
        cbm_pkg::DEC_UNUSED: ;
        cbm_pkg::DEC_IRQ_COUNT: irq_cnt = data;
        cbm_pkg::DEC_IRQ_RELOAD: irq_rld = data;
        cbm_pkg::DEC_IRQ_DISABLE: begin
          // This one also sets the mirroring, even on four-screen carts.
          irq_on = 1'b0;
          mirror = (data == 8'd0);
        end
        cbm_pkg::DEC_IRQ_ENABLE: irq_on = 1'b1;
        default: ;
      endcase
    endfunction

    // Returns 1 when the tick raises the interrupt.
    function logic clock_irq(logic [8:0] line, logic rendering);
      if (!irq_on || line > cbm_pkg::LAST_VISIBLE_LINE || !rendering) return 1'b0;
      if (irq_cnt == 8'd0) begin
        irq_cnt = irq_rld;
        return 1'b1;
      end
      irq_cnt = irq_cnt - 8'd1;
      return 1'b0;
    endfunction

    function void note_input(cbm_pkg::in_item_t it);
      cbm_pkg::out_item_t want;
      logic [7:0] fixed_last;
      logic [7:0] fixed_prev;
      logic [7:0] lo[4];
      logic [7:0] hi[4];
      want = '0;
      if (it.mode == MODE_TICK) want.irq_pulse = clock_irq(it.line_number, it.rendering_on);
      else apply_write(it.address, it.write_data);

      // The fixed slots wrap modulo 256 for any bank count.
      fixed_last = prg_count[7:0] - 8'd1;
      fixed_prev = prg_count[7:0] - 8'd2;
      if (bank_sel[cbm_pkg::SEL_PRG_SWAP_BIT])
        want.prg_bank_map = {fixed_last, prg_regs[0], prg_regs[1], fixed_prev};
      else
        want.prg_bank_map = {fixed_last, fixed_prev, prg_regs[1], prg_regs[0]};

      lo[0] = chr_regs[0];
      lo[1] = chr_regs[0] + 8'd1;
      lo[2] = chr_regs[1];
      lo[3] = chr_regs[1] + 8'd1;
      for (int i = 0; i < 4; i++) hi[i] = chr_regs[2 + i];
      if (chr_rom) begin
        for (int i = 0; i < 4; i++) begin
          if (bank_sel[cbm_pkg::SEL_CHR_SWAP_BIT]) begin
            want.chr_bank_map[8*i +: 8]     = hi[i];
            want.chr_bank_map[8*(4+i) +: 8] = lo[i];
          end else begin
            want.chr_bank_map[8*i +: 8]     = lo[i];
            want.chr_bank_map[8*(4+i) +: 8] = hi[i];
          end
        end
      end
      want.mirroring = mirror;
      expected_q.push_back(want);
    endfunction

    function void check_result(cbm_pkg::out_item_t got);
      cbm_pkg::out_item_t want;
      if (expected_q.size() == 0) begin
        $error("result transfer with nothing expected: %h", got);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      if (got.prg_bank_map !== want.prg_bank_map) begin
        $error("prg_bank_map: expected %h, got %h", want.prg_bank_map, got.prg_bank_map);
        errors++;
      end
      if (got.chr_bank_map !== want.chr_bank_map) begin
        $error("chr_bank_map: expected %h, got %h", want.chr_bank_map, got.chr_bank_map);
        errors++;
      end
      if (got.mirroring !== want.mirroring) begin
        $error("mirroring: expected %b, got %b", want.mirroring, got.mirroring);
        errors++;
      end
      if (got.irq_pulse !== want.irq_pulse) begin
        $error("irq_pulse: expected %b, got %b", want.irq_pulse, got.irq_pulse);
        errors++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  // Every input of the block has a known value from time zero.
  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           in_valid = 1'b0;
  logic                           in_ready;
  cbm_pkg::in_item_t              in_data = '0;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  cbm_pkg::out_item_t             out_data;
  logic                           cfg_we = 1'b0;
  logic [1:0]                     cfg_index = '0;
  logic [cbm_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  // When steady is set the sender inserts no idle cycles and the receiver starts no random stalls.
  logic steady = 1'b0;
  // Each bump of hold_ticket asks the receiver for one long hold-off.
  int   hold_ticket = 0;
  int   hold_seen = 0;
  int   stall_left = 0;
  int   rx_gap;
  int   sent = 0;

  mapper_scoreboard sb;

  cartridge_bank_mapper_irq_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // Idle lengths: mostly none or short, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  // Receiver side. It drops ready for random stretches and, on request, for one
  // long hold-off so that the output register fills and the input stalls.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      stall_left <= 0;
    end else if (hold_ticket != hold_seen) begin
      hold_seen <= hold_ticket;
      out_ready <= 1'b0;
      stall_left <= LONG_HOLD;
    end else if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (steady) begin
      out_ready <= 1'b1;
    end else begin
      rx_gap = pick_gap();
      out_ready <= (rx_gap == 0);
      stall_left <= (rx_gap > 0) ? rx_gap - 1 : 0;
    end
  end

  // Result transfers are checked on the values present before the edge.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_result(out_data);
  end

  // A random address inside the window of one register decode.
  function automatic logic [15:0] addr_of(input logic [3:0] dec);
    return {dec[3:1], 12'($urandom), dec[0]};
  endfunction

  // Fields that a transfer kind does not use still carry random values.
  function automatic cbm_pkg::in_item_t mk_write(input logic [15:0] addr,
                                                 input logic [7:0] data);
    cbm_pkg::in_item_t it;
    it.mode = MODE_WRITE;
    it.address = addr;
    it.write_data = data;
    it.line_number = 9'($urandom_range(0, LAST_LINE));
    it.rendering_on = 1'($urandom_range(0, 1));
    return it;
  endfunction

  function automatic cbm_pkg::in_item_t mk_tick(input logic [8:0] line,
                                                input logic rendering);
    cbm_pkg::in_item_t it;
    it.mode = MODE_TICK;
    it.address = 16'($urandom);
    it.write_data = 8'($urandom);
    it.line_number = line;
    it.rendering_on = rendering;
    return it;
  endfunction

  // Mostly visible lines with rendering on, so that the counter really runs.
  function automatic cbm_pkg::in_item_t rand_tick();
    logic [8:0] line;
    if ($urandom_range(0, 99) < 85)
      line = 9'($urandom_range(0, cbm_pkg::LAST_VISIBLE_LINE));
    else line = 9'($urandom_range(cbm_pkg::LAST_VISIBLE_LINE + 1, LAST_LINE));
    return mk_tick(line, $urandom_range(0, 9) != 0);
  endfunction

  function automatic cbm_pkg::in_item_t rand_noise();
    cbm_pkg::in_item_t it;
    it.mode = 1'($urandom_range(0, 1));
    it.address = 16'($urandom);
    it.write_data = 8'($urandom);
    it.line_number = 9'($urandom_range(0, LAST_LINE));
    it.rendering_on = 1'($urandom_range(0, 1));
    return it;
  endfunction

  // Offers one item after an optional idle gap and returns at the edge of its
  // transfer. Valid is only lowered when a gap follows, so back-to-back items
  // keep it high.
  task automatic send_item(input cbm_pkg::in_item_t it);
    int gap;
    gap = steady ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_input(it);
    sent++;
  endtask

  // Configuration writes happen only while the block is idle. The write enable
  // stays high across a run of writes and is lowered by the caller.
  task automatic cfg_write(input logic [1:0] idx,
                           input logic [cbm_pkg::CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    sb.write_cfg(idx, val);
  endtask

  // The one-bit registers get random upper bits, which the block must ignore.
  task automatic program_cart(input logic [8:0] count, input logic chr, input logic four,
                              input logic mirr);
    cfg_write(cbm_pkg::CFG_PRG_BANK_COUNT, count);
    cfg_write(cbm_pkg::CFG_HAS_CHR_ROM, {8'($urandom), chr});
    cfg_write(cbm_pkg::CFG_FOUR_SCREEN, {8'($urandom), four});
    cfg_write(cbm_pkg::CFG_INITIAL_MIRRORING, {8'($urandom), mirr});
    cfg_we <= 1'b0;
  endtask

  // Waits until every expected result has come back, then for the drain period DRAIN_CYCLES.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Register extremes, every decode, and the tick cases that must be ignored.
  task automatic run_directed();
    send_item(mk_tick(9'd0, 1'b1));                        // tick while not armed
    send_item(mk_write(16'h7FFF, 8'hFF));                  // below the mapper window
    send_item(mk_write(16'h8000, 8'h00));                  // select program register 0
    send_item(mk_write(addr_of(cbm_pkg::DEC_BANK_DATA), 8'hFF));
    send_item(mk_write(addr_of(cbm_pkg::DEC_BANK_SELECT), 8'h01));
    send_item(mk_write(addr_of(cbm_pkg::DEC_BANK_DATA), 8'h00));
    send_item(mk_write(addr_of(cbm_pkg::DEC_BANK_SELECT), 8'h02));  // pair, odd value
    send_item(mk_write(addr_of(cbm_pkg::DEC_BANK_DATA), 8'hFF));
    send_item(mk_write(addr_of(cbm_pkg::DEC_BANK_SELECT), 8'h83));  // pattern swap
    send_item(mk_write(addr_of(cbm_pkg::DEC_BANK_DATA), 8'h01));
    send_item(mk_write(addr_of(cbm_pkg::DEC_BANK_SELECT), 8'h47));  // program swap
    send_item(mk_write(addr_of(cbm_pkg::DEC_BANK_DATA), 8'hFF));
    send_item(mk_write(addr_of(cbm_pkg::DEC_MIRROR), 8'hFF));
    send_item(mk_write(addr_of(cbm_pkg::DEC_UNUSED), 8'hFF));
    send_item(mk_write(addr_of(cbm_pkg::DEC_IRQ_COUNT), 8'h01));
    send_item(mk_write(addr_of(cbm_pkg::DEC_IRQ_RELOAD), 8'hFF));
    send_item(mk_write(16'hFFFF, 8'h00));                  // arm
    send_item(mk_tick(cbm_pkg::LAST_VISIBLE_LINE, 1'b1));          // last visible line
    send_item(mk_tick(cbm_pkg::LAST_VISIBLE_LINE + 9'd1, 1'b1));   // first blank line
    send_item(mk_tick(9'(LAST_LINE), 1'b1));
    send_item(mk_tick(9'd5, 1'b0));                        // rendering off is ignored
    send_item(mk_tick(9'd0, 1'b1));                        // zero count reloads and fires
    send_item(mk_write(addr_of(cbm_pkg::DEC_IRQ_DISABLE), 8'h00));
    send_item(mk_write(addr_of(cbm_pkg::DEC_IRQ_DISABLE), 8'h80));
    send_item(mk_tick(9'd10, 1'b1));                       // disarmed again
  endtask

  // Random traffic is built from short well-formed sequences (bank select then
  // bank data, counter setup then arm, runs of ticks), single register writes and some noise.
  task automatic run_random(input int n);
    int target;
    int kind;
    target = sent + n;
    while (sent < target) begin
      kind = $urandom_range(0, 99);
      if (kind < 30) begin
        send_item(mk_write(addr_of(cbm_pkg::DEC_BANK_SELECT), 8'($urandom)));
        send_item(mk_write(addr_of(cbm_pkg::DEC_BANK_DATA), 8'($urandom)));
      end else if (kind < 45) begin
        send_item(mk_write(addr_of(cbm_pkg::DEC_IRQ_COUNT), 8'($urandom_range(0, 6))));
        send_item(mk_write(addr_of(cbm_pkg::DEC_IRQ_RELOAD), 8'($urandom_range(0, 6))));
        send_item(mk_write(addr_of(cbm_pkg::DEC_IRQ_ENABLE), 8'($urandom)));
      end else if (kind < 75) begin
        repeat ($urandom_range(1, 6)) send_item(rand_tick());
      end else if (kind < 88) begin
        case ($urandom_range(0, 3))
          0: send_item(mk_write(addr_of(cbm_pkg::DEC_MIRROR), 8'($urandom)));
          1: send_item(mk_write(addr_of(cbm_pkg::DEC_UNUSED), 8'($urandom)));
          2: send_item(mk_write(addr_of(cbm_pkg::DEC_IRQ_DISABLE),
                                ($urandom_range(0, 1) != 0) ? 8'd0 : 8'($urandom)));
          default: send_item(mk_write(addr_of(cbm_pkg::DEC_IRQ_ENABLE), 8'($urandom)));
        endcase
      end else begin
        send_item(rand_noise());
      end
    end
  endtask

  // Each phase opens with a stretch with no sender gaps and no new random receiver stalls.
  task automatic run_phase(input int n);
    steady <= 1'b1;
    run_random(n / 4);
    steady <= 1'b0;
    run_random(n - n / 4);
  endtask

  initial begin
    sb = new();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    program_cart(cbm_pkg::RST_PRG_BANK_COUNT, cbm_pkg::RST_HAS_CHR_ROM,
                 cbm_pkg::RST_FOUR_SCREEN, cbm_pkg::RST_INITIAL_MIRRORING);
    run_directed();
    run_phase(70);
    wait_idle();

    // Smallest legal bank count on a four-screen cart.
    program_cart(9'd2, 1'b1, 1'b1, 1'b1);
    run_phase(90);
    wait_idle();

    // Largest legal bank count without pattern ROM; the receiver holds off once.
    program_cart(9'd256, 1'b0, 1'b0, 1'b1);
    hold_ticket <= hold_ticket + 1;
    run_phase(90);
    wait_idle();

    // Bank counts outside the legal range wrap in the fixed slots.
    program_cart(9'd0, 1'b1, 1'b1, 1'b0);
    run_phase(90);
    wait_idle();

    program_cart(9'd511, 1'b0, 1'b1, 1'b1);
    run_phase(80);
    wait_idle();

    program_cart(9'd1, 1'b1, 1'b0, 1'b0);
    run_phase(80);
    wait_idle();

    program_cart(9'($urandom_range(0, 511)), 1'($urandom_range(0, 1)),
                 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    hold_ticket <= hold_ticket + 1;
    run_phase(90);
    wait_idle();

    if (sb.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #TIMEOUT_NS;
    $display("== FAIL ==");
    $finish;
  end

endmodule
